/* rtl/bdn_pkg.sv */
// ----------------------------------------------------------------------------
// bdn_pkg
// Shared widths, register indexes and pipeline payload types of the box
// distance and normal pipeline.
// ----------------------------------------------------------------------------
package bdn_pkg;

  // coordinate and result widths
  localparam int CW   = 24;          // point, centre, distance
  localparam int HW   = 23;          // half extents, sweep length
  localparam int QW   = 25;          // translated coordinate, signed
  localparam int DW   = 26;          // per-axis excess, signed
  localparam int EW   = 25;          // positive excess, unsigned
  localparam int SW   = 50;          // sum of squared excesses
  localparam int LW   = 25;          // root
  localparam int RW   = 27;          // root remainder
  localparam int NW   = 18;          // normal component
  localparam int QB   = 17;          // quotient bits of a normal divide
  localparam int DNW  = 43;          // divide numerator
  localparam int DDW  = 26;          // divide divisor
  localparam int SQ_STAGES = LW;
  localparam int DIV_STAGES = QB;

  localparam logic signed [CW-1:0] DIST_MAX = 24'sh7FFFFF;
  localparam logic signed [NW-1:0] ONE_Q16  = 18'sd65536;

  // register indexes
  localparam logic [2:0] REG_SWEEP_EN  = 3'd0;
  localparam logic [2:0] REG_HALF_X    = 3'd1;
  localparam logic [2:0] REG_HALF_Y    = 3'd2;
  localparam logic [2:0] REG_HALF_Z    = 3'd3;
  localparam logic [2:0] REG_SWEEP_LEN = 3'd4;
  localparam logic [2:0] REG_CENTER_X  = 3'd5;
  localparam logic [2:0] REG_CENTER_Y  = 3'd6;
  localparam logic [2:0] REG_CENTER_Z  = 3'd7;

  typedef struct packed {
    logic                 sweep_en;
    logic [HW-1:0]        half_x;
    logic [HW-1:0]        half_y;
    logic [HW-1:0]        half_z;
    logic [HW-1:0]        sweep_len;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
  } bdn_cfg_t;

  // carried alongside the root
  typedef struct packed {
    logic [2:0]           neg;
    logic                 outside;
    logic [1:0]           axis;
    logic signed [CW-1:0] dist_in;
    logic [EW-1:0]        e0;
    logic [EW-1:0]        e1;
    logic [EW-1:0]        e2;
  } bdn_side_t;

  // carried alongside the divides
  typedef struct packed {
    logic [2:0]           neg;
    logic                 outside;
    logic [1:0]           axis;
    logic signed [CW-1:0] dist_in;
    logic [LW-1:0]        len;
  } bdn_tail_t;

endpackage

/* rtl/bdn_front.sv */
// ----------------------------------------------------------------------------
// bdn_front
// Translate, sweep, excess, squares and sum: five register stages.
// ----------------------------------------------------------------------------
module bdn_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  bdn_pkg::bdn_cfg_t             cfg,
  input  logic                          in_v,
  input  logic signed [bdn_pkg::CW-1:0] px,
  input  logic signed [bdn_pkg::CW-1:0] py,
  input  logic signed [bdn_pkg::CW-1:0] pz,
  output logic                          out_v,
  output logic [bdn_pkg::SW-1:0]        sum,
  output bdn_pkg::bdn_side_t            side
);

  localparam int QW = bdn_pkg::QW;
  localparam int DW = bdn_pkg::DW;
  localparam int EW = bdn_pkg::EW;
  localparam int SW = bdn_pkg::SW;
  localparam int CW = bdn_pkg::CW;

  logic [4:0] v_r;

  // stage 1 translate
  logic signed [QW-1:0] q1_r [3];
  // stage 2 sweep
  logic signed [QW-1:0] q2_r [3];
  logic signed [QW-1:0] q2_nxt;
  // stage 3 excess
  logic signed [DW-1:0] d3_r [3];
  logic [EW-1:0]        e3_r [3];
  logic [2:0]           neg3_r;
  // stage 4 squares, largest excess
  logic [SW-1:0]        sq4_r [3];
  logic [EW-1:0]        e4_r [3];
  logic [2:0]           neg4_r;
  logic [1:0]           axis4_r, axis4_nxt;
  logic signed [DW-1:0] max4_r, max4_nxt;
  // stage 5 sum
  logic [SW-1:0]        sum5_r;
  bdn_pkg::bdn_side_t   side5_r;

  logic [bdn_pkg::HW-1:0] half [3];
  logic [QW-1:0]          mag  [3];
  logic signed [DW-1:0]   dd   [3];

  assign half[0] = cfg.half_x;
  assign half[1] = cfg.half_y;
  assign half[2] = cfg.half_z;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_v};
    end
  end

  // sweep reduction of x
  always_comb begin
    q2_nxt = q1_r[0];
    if (cfg.sweep_en && !q1_r[0][QW-1]) begin
      if (q1_r[0] > $signed({2'b00, cfg.sweep_len})) begin
        q2_nxt = q1_r[0] - $signed({2'b00, cfg.sweep_len});
      end else begin
        q2_nxt = '0;
      end
    end
  end

  // magnitude and excess per axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = q2_r[i][QW-1] ? QW'(-q2_r[i]) : QW'(q2_r[i]);
      dd[i]  = $signed({1'b0, mag[i]}) - $signed({3'b000, half[i]});
    end
  end

  // largest excess, ties to the lowest axis
  always_comb begin
    axis4_nxt = 2'd0;
    max4_nxt  = d3_r[0];
    if (d3_r[1] > max4_nxt) begin
      max4_nxt  = d3_r[1];
      axis4_nxt = 2'd1;
    end
    if (d3_r[2] > max4_nxt) begin
      max4_nxt  = d3_r[2];
      axis4_nxt = 2'd2;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      q1_r[0] <= $signed({px[CW-1], px}) - $signed({cfg.center_x[CW-1], cfg.center_x});
      q1_r[1] <= $signed({py[CW-1], py}) - $signed({cfg.center_y[CW-1], cfg.center_y});
      q1_r[2] <= $signed({pz[CW-1], pz}) - $signed({cfg.center_z[CW-1], cfg.center_z});

      q2_r[0] <= q2_nxt;
      q2_r[1] <= q1_r[1];
      q2_r[2] <= q1_r[2];

      for (int i = 0; i < 3; i++) begin
        d3_r[i]   <= dd[i];
        e3_r[i]   <= (dd[i] > 0) ? dd[i][EW-1:0] : '0;
        neg3_r[i] <= q2_r[i][QW-1];
        sq4_r[i]  <= e3_r[i] * e3_r[i];
        e4_r[i]   <= e3_r[i];
      end
      neg4_r  <= neg3_r;
      axis4_r <= axis4_nxt;
      max4_r  <= max4_nxt;

      sum5_r          <= sq4_r[0] + sq4_r[1] + sq4_r[2];
      side5_r.neg     <= neg4_r;
      side5_r.outside <= (max4_r > 0);
      side5_r.axis    <= axis4_r;
      side5_r.dist_in <= max4_r[CW-1:0];
      side5_r.e0      <= e4_r[0];
      side5_r.e1      <= e4_r[1];
      side5_r.e2      <= e4_r[2];
    end
  end

  assign out_v = v_r[4];
  assign sum   = sum5_r;
  assign side  = side5_r;

endmodule

/* rtl/bdn_sqrt.sv */
// ----------------------------------------------------------------------------
// bdn_sqrt
// Pipelined integer square root, one root bit per stage, remainder kept.
// ----------------------------------------------------------------------------
module bdn_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_v,
  input  logic [bdn_pkg::SW-1:0] s_in,
  input  bdn_pkg::bdn_side_t     side_in,
  output logic                   out_v,
  output logic [bdn_pkg::LW-1:0] root,
  output logic [bdn_pkg::RW-1:0] rem,
  output bdn_pkg::bdn_side_t     side_out
);

  localparam int N  = bdn_pkg::SQ_STAGES;
  localparam int SW = bdn_pkg::SW;
  localparam int LW = bdn_pkg::LW;
  localparam int RW = bdn_pkg::RW;

  logic               v_a    [N+1];
  logic [SW-1:0]      s_a    [N+1];
  logic [LW-1:0]      root_a [N+1];
  logic [RW-1:0]      rem_a  [N+1];
  bdn_pkg::bdn_side_t side_a [N+1];

  assign v_a[0]    = in_v;
  assign s_a[0]    = s_in;
  assign root_a[0] = '0;
  assign rem_a[0]  = '0;
  assign side_a[0] = side_in;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic          take;
    logic          v_r;
    logic [SW-1:0] s_r;
    logic [LW-1:0] root_r;
    logic [RW-1:0] rem_r;
    bdn_pkg::bdn_side_t side_r;

    // bring down the next two radicand bits and try a one digit
    assign rem_sh = {rem_a[i], s_a[i][SW-1-2*i -: 2]};
    assign trial  = {2'b00, root_a[i], 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_a[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r    <= s_a[i];
        side_r <= side_a[i];
        root_r <= {root_a[i][LW-2:0], take};
        rem_r  <= take ? RW'(rem_sh - trial) : RW'(rem_sh);
      end
    end

    assign v_a[i+1]    = v_r;
    assign s_a[i+1]    = s_r;
    assign root_a[i+1] = root_r;
    assign rem_a[i+1]  = rem_r;
    assign side_a[i+1] = side_r;
  end

  assign out_v    = v_a[N];
  assign root     = root_a[N];
  assign rem      = rem_a[N];
  assign side_out = side_a[N];

endmodule

/* rtl/bdn_div.sv */
// ----------------------------------------------------------------------------
// bdn_div
// Pipelined restoring divider for one normal component, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module bdn_div (
  input  logic                    clk,
  input  logic                    en,
  input  logic [bdn_pkg::DNW-1:0] num,
  input  logic [bdn_pkg::DDW-1:0] den,
  output logic [bdn_pkg::QB-1:0]  quo
);

  localparam int N   = bdn_pkg::DIV_STAGES;
  localparam int DNW = bdn_pkg::DNW;
  localparam int DDW = bdn_pkg::DDW;
  localparam int QB  = bdn_pkg::QB;

  logic [DNW-1:0] rem_a [N+1];
  logic [DDW-1:0] den_a [N+1];
  logic [QB-1:0]  quo_a [N+1];

  assign rem_a[0] = num;
  assign den_a[0] = den;
  assign quo_a[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [DNW-1:0] dk;
    logic           take;
    logic [DNW-1:0] rem_r;
    logic [DDW-1:0] den_r;
    logic [QB-1:0]  quo_r;

    // divisor aligned to the current quotient bit
    assign dk   = {{(DNW-DDW){1'b0}}, den_a[i]} << (N-1-i);
    assign take = (rem_a[i] >= dk);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= take ? (rem_a[i] - dk) : rem_a[i];
        den_r <= den_a[i];
        quo_r <= {quo_a[i][QB-2:0], take};
      end
    end

    assign rem_a[i+1] = rem_r;
    assign den_a[i+1] = den_r;
    assign quo_a[i+1] = quo_r;
  end

  assign quo = quo_a[N];

endmodule

/* rtl/box_distance_and_normal.sv */
// ----------------------------------------------------------------------------
// box_distance_and_normal
// Signed distance and unit gradient of an axis-aligned box, Q7.16 in,
// Q7.16 distance and Q1.16 normal out.
// ----------------------------------------------------------------------------
// One point enters per cycle while in_ready is high. Its result passes
// through the translate, sweep, excess, squares and sum stages, the
// bit-per-stage square root, a rounding register, the bit-per-stage
// normal dividers and one output register. The whole pipeline advances
// together; while a result waits on out_ready, in_ready is low, and bubbles
// in flight are not squeezed out. Configuration is taken from the live
// registers, so write it only while no transaction is in flight.
module box_distance_and_normal (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_addr,
  input  logic [bdn_pkg::CW-1:0]        cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [bdn_pkg::CW-1:0] in_point_x,
  input  logic signed [bdn_pkg::CW-1:0] in_point_y,
  input  logic signed [bdn_pkg::CW-1:0] in_point_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [bdn_pkg::CW-1:0] out_distance,
  output logic signed [bdn_pkg::NW-1:0] out_normal_x,
  output logic signed [bdn_pkg::NW-1:0] out_normal_y,
  output logic signed [bdn_pkg::NW-1:0] out_normal_z
);

  localparam int CW  = bdn_pkg::CW;
  localparam int HW  = bdn_pkg::HW;
  localparam int LW  = bdn_pkg::LW;
  localparam int RW  = bdn_pkg::RW;
  localparam int SW  = bdn_pkg::SW;
  localparam int NW  = bdn_pkg::NW;
  localparam int QB  = bdn_pkg::QB;
  localparam int DNW = bdn_pkg::DNW;
  localparam int DDW = bdn_pkg::DDW;
  localparam int EW  = bdn_pkg::EW;
  localparam int ND  = bdn_pkg::DIV_STAGES;

  bdn_pkg::bdn_cfg_t cfg_r;
  logic              en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sweep_en  <= 1'b0;
      cfg_r.half_x    <= HW'(13107);
      cfg_r.half_y    <= HW'(13107);
      cfg_r.half_z    <= HW'(13107);
      cfg_r.sweep_len <= HW'(52429);
      cfg_r.center_x  <= '0;
      cfg_r.center_y  <= '0;
      cfg_r.center_z  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        bdn_pkg::REG_SWEEP_EN:  cfg_r.sweep_en  <= cfg_wdata[0];
        bdn_pkg::REG_HALF_X:    cfg_r.half_x    <= cfg_wdata[HW-1:0];
        bdn_pkg::REG_HALF_Y:    cfg_r.half_y    <= cfg_wdata[HW-1:0];
        bdn_pkg::REG_HALF_Z:    cfg_r.half_z    <= cfg_wdata[HW-1:0];
        bdn_pkg::REG_SWEEP_LEN: cfg_r.sweep_len <= cfg_wdata[HW-1:0];
        bdn_pkg::REG_CENTER_X:  cfg_r.center_x  <= $signed(cfg_wdata);
        bdn_pkg::REG_CENTER_Y:  cfg_r.center_y  <= $signed(cfg_wdata);
        bdn_pkg::REG_CENTER_Z:  cfg_r.center_z  <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // global advance: the output register is free or being taken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // front stages
  logic               fr_v;
  logic [SW-1:0]      fr_sum;
  bdn_pkg::bdn_side_t fr_side;

  bdn_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cfg   (cfg_r),
    .in_v  (in_valid && in_ready),
    .px    (in_point_x),
    .py    (in_point_y),
    .pz    (in_point_z),
    .out_v (fr_v),
    .sum   (fr_sum),
    .side  (fr_side)
  );

  // square root
  logic               sq_v;
  logic [LW-1:0]      sq_root;
  logic [RW-1:0]      sq_rem;
  bdn_pkg::bdn_side_t sq_side;

  bdn_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (fr_v),
    .s_in     (fr_sum),
    .side_in  (fr_side),
    .out_v    (sq_v),
    .root     (sq_root),
    .rem      (sq_rem),
    .side_out (sq_side)
  );

  // round to nearest and set up the divides
  logic               rd_v_r;
  bdn_pkg::bdn_tail_t rd_tail_r;
  logic [EW-1:0]      rd_e_r [3];
  logic [LW-1:0]      len_nxt;

  assign len_nxt = sq_root + LW'({{(RW-1){1'b0}}, sq_rem > {{(RW-LW){1'b0}}, sq_root}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else if (en) begin
      rd_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_tail_r.neg     <= sq_side.neg;
      rd_tail_r.outside <= sq_side.outside;
      rd_tail_r.axis    <= sq_side.axis;
      rd_tail_r.dist_in <= sq_side.dist_in;
      rd_tail_r.len     <= len_nxt;
      rd_e_r[0]         <= sq_side.e0;
      rd_e_r[1]         <= sq_side.e1;
      rd_e_r[2]         <= sq_side.e2;
    end
  end

  // normal dividers: (e * 2^17 + len) / (2 * len)
  logic [DDW-1:0] den;
  logic [QB-1:0]  quo [3];

  assign den = {rd_tail_r.len, 1'b0};

  for (genvar a = 0; a < 3; a++) begin : g_div
    logic [DNW-1:0] num;
    assign num = {{(DNW-EW-QB){1'b0}}, rd_e_r[a], {QB{1'b0}}}
               + {{(DNW-LW){1'b0}}, rd_tail_r.len};

    bdn_div u_div (
      .clk (clk),
      .en  (en),
      .num (num),
      .den (den),
      .quo (quo[a])
    );
  end

  // side data travels beside the dividers
  logic               tl_v_r    [ND];
  bdn_pkg::bdn_tail_t tl_tail_r [ND];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ND; i++) tl_v_r[i] <= 1'b0;
    end else if (en) begin
      tl_v_r[0] <= rd_v_r;
      for (int i = 1; i < ND; i++) tl_v_r[i] <= tl_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tl_tail_r[0] <= rd_tail_r;
      for (int i = 1; i < ND; i++) tl_tail_r[i] <= tl_tail_r[i-1];
    end
  end

  // result assembly
  bdn_pkg::bdn_tail_t   tl;
  logic signed [CW-1:0] dist_nxt;
  logic signed [NW-1:0] nrm_nxt [3];
  logic signed [NW-1:0] mag;
  logic                 out_valid_r;
  logic signed [CW-1:0] dist_r;
  logic signed [NW-1:0] nrm_r [3];

  assign tl = tl_tail_r[ND-1];

  always_comb begin
    mag = '0;
    if (tl.outside) begin
      dist_nxt = (tl.len > LW'(bdn_pkg::DIST_MAX)) ? bdn_pkg::DIST_MAX
                                                   : CW'(tl.len);
    end else begin
      dist_nxt = tl.dist_in;
    end
    for (int i = 0; i < 3; i++) begin
      if (tl.outside) begin
        mag = ($signed({1'b0, quo[i]}) > bdn_pkg::ONE_Q16) ? bdn_pkg::ONE_Q16
                                                          : $signed({1'b0, quo[i]});
        nrm_nxt[i] = tl.neg[i] ? -mag : mag;
      end else if (tl.axis == 2'(i)) begin
        nrm_nxt[i] = tl.neg[i] ? -bdn_pkg::ONE_Q16 : bdn_pkg::ONE_Q16;
      end else begin
        nrm_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tl_v_r[ND-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= dist_nxt;
      for (int i = 0; i < 3; i++) nrm_r[i] <= nrm_nxt[i];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = dist_r;
  assign out_normal_x = nrm_r[0];
  assign out_normal_y = nrm_r[1];
  assign out_normal_z = nrm_r[2];

endmodule
